/* sv/mpr_pkg.sv */
// mpr_pkg: shared constants, types and register codes for the mask pyramid reducer.
// Used by every module of the block; no dependencies of its own.
package mpr_pkg;

  // sizing of the line buffer and the datapath
  localparam int MAX_WIDTH   = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int HALF_SLOTS  = MAX_WIDTH / 2;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int SLOT_W      = $clog2(HALF_SLOTS);
  localparam int ROW_W       = 16;
  localparam int WIDTH_REG_W = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int MAG_W       = SAMPLE_BITS;
  localparam int PAIR_W      = SAMPLE_BITS + 1;
  localparam int ROW_SUM_W   = SAMPLE_BITS + 2;
  localparam int SUM_W       = 19;

  // configuration register indexes
  localparam logic [0:0] REG_FULL_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FULL_HEIGHT = 1'b1;

  // register reset values
  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = WIDTH_REG_W'(1024);
  localparam logic [ROW_W-1:0]       HEIGHT_RESET = ROW_W'(1024);

  // per-request control carried from the input register to the accumulate stage
  typedef struct packed {
    logic              active;     // inside the even-sized part of the frame
    logic              odd_col;
    logic              odd_row;
    logic              first_col;
    logic              first_row;
    logic              last;       // final half pixel of the frame
    logic [SLOT_W-1:0] slot;       // half column
  } stage_ctrl_t;

endpackage

/* sv/mpr_line_buf.sv */
// mpr_line_buf: one-row buffer of per-half-column partial sums.
// One write and one registered read port, with write-to-read forwarding.
// Depends on mpr_pkg.
module mpr_line_buf (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [mpr_pkg::SLOT_W-1:0] wr_slot_i,
  input  logic [mpr_pkg::SUM_W-1:0]  wr_data_i,
  input  logic                       rd_en_i,
  input  logic [mpr_pkg::SLOT_W-1:0] rd_slot_i,
  output logic [mpr_pkg::SUM_W-1:0]  rd_data_o
);

  logic [mpr_pkg::SUM_W-1:0] mem_q [mpr_pkg::HALF_SLOTS];
  logic [mpr_pkg::SUM_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_slot_i] <= wr_data_i;
    end
  end

  // read port; a same-edge write to the same slot is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_slot_i == rd_slot_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_slot_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/mpr_input_stage.sv */
// mpr_input_stage: configuration registers, raster position counters and input register.
// Issues the line buffer read for each even column. Depends on mpr_pkg.
module mpr_input_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_index_i,
  input  logic [mpr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              sample_valid_i,
  output logic                              sample_ready_o,
  input  logic signed [mpr_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                              s1_advance_i,
  output logic                              s1_valid_o,
  output logic [mpr_pkg::SAMPLE_BITS-1:0]   s1_sample_o,
  output mpr_pkg::stage_ctrl_t              s1_ctrl_o,
  output logic                              rd_en_o,
  output logic [mpr_pkg::SLOT_W-1:0]        rd_slot_o
);

  logic [mpr_pkg::WIDTH_REG_W-1:0] width_q;
  logic [mpr_pkg::ROW_W-1:0]       height_q;
  logic [mpr_pkg::COL_W-1:0]       col_q, col_d;
  logic [mpr_pkg::ROW_W-1:0]       row_q, row_d;
  logic                            s1_valid_q;
  logic [mpr_pkg::SAMPLE_BITS-1:0] s1_sample_q;
  mpr_pkg::stage_ctrl_t            s1_ctrl_q, ctrl_d;

  logic [mpr_pkg::WIDTH_REG_W-1:0] eff_w;
  logic [mpr_pkg::ROW_W-1:0]       eff_h;
  logic [mpr_pkg::COL_W-1:0]       half_w;
  logic [mpr_pkg::ROW_W-2:0]       half_h;
  logic [mpr_pkg::ROW_W-2:0]       half_row;
  logic [mpr_pkg::SLOT_W-1:0]      slot;
  logic                            accept;
  logic                            col_wrap;
  logic                            row_wrap;

  // effective frame size, clamped to the supported range
  always_comb begin
    if (width_q < mpr_pkg::WIDTH_REG_W'(2)) begin
      eff_w = mpr_pkg::WIDTH_REG_W'(2);
    end else if (width_q > mpr_pkg::WIDTH_REG_W'(mpr_pkg::MAX_WIDTH)) begin
      eff_w = mpr_pkg::WIDTH_REG_W'(mpr_pkg::MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q < mpr_pkg::ROW_W'(2)) ? mpr_pkg::ROW_W'(2) : height_q;
  end

  assign half_w   = eff_w[mpr_pkg::WIDTH_REG_W-1:1];
  assign half_h   = eff_h[mpr_pkg::ROW_W-1:1];
  assign slot     = col_q[mpr_pkg::COL_W-1:1];
  assign half_row = row_q[mpr_pkg::ROW_W-1:1];

  assign sample_ready_o = !s1_valid_q || s1_advance_i;
  assign accept         = sample_valid_i && sample_ready_o;

  // classify the current position
  always_comb begin
    ctrl_d.active    = (mpr_pkg::COL_W'(slot) < half_w) && (half_row < half_h);
    ctrl_d.odd_col   = col_q[0];
    ctrl_d.odd_row   = row_q[0];
    ctrl_d.first_col = (col_q == '0);
    ctrl_d.first_row = (row_q == '0);
    ctrl_d.last      = (half_row == half_h - 1'b1) &&
                       (mpr_pkg::COL_W'(slot) == half_w - 1'b1);
    ctrl_d.slot      = slot;
  end

  // raster position advance
  assign col_wrap = ({1'b0, col_q} + 1'b1) >= eff_w;
  assign row_wrap = ({1'b0, row_q} + 1'b1) >= {1'b0, eff_h};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // configuration writes restart the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mpr_pkg::WIDTH_RESET;
      height_q <= mpr_pkg::HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mpr_pkg::REG_FULL_WIDTH:  width_q  <= cfg_data_i[mpr_pkg::WIDTH_REG_W-1:0];
        mpr_pkg::REG_FULL_HEIGHT: height_q <= cfg_data_i[mpr_pkg::ROW_W-1:0];
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= sample_i;
      s1_ctrl_q   <= ctrl_d;
    end
  end

  // even column fetches the pending half-column sum
  assign rd_en_o   = accept && ctrl_d.active && !ctrl_d.odd_col;
  assign rd_slot_o = slot;

  assign s1_valid_o  = s1_valid_q;
  assign s1_sample_o = s1_sample_q;
  assign s1_ctrl_o   = s1_ctrl_q;

endmodule

/* sv/mpr_accum_stage.sv */
// mpr_accum_stage: magnitude, row and column accumulation, and the result register.
// Writes the line buffer on odd columns. Depends on mpr_pkg.
module mpr_accum_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s1_valid_i,
  input  logic [mpr_pkg::SAMPLE_BITS-1:0]   s1_sample_i,
  input  mpr_pkg::stage_ctrl_t              s1_ctrl_i,
  output logic                              s1_advance_o,
  input  logic [mpr_pkg::SUM_W-1:0]         rd_data_i,
  output logic                              wr_en_o,
  output logic [mpr_pkg::SLOT_W-1:0]        wr_slot_o,
  output logic [mpr_pkg::SUM_W-1:0]         wr_data_o,
  output logic                              result_valid_o,
  input  logic                              result_ready_i,
  output logic [mpr_pkg::SUM_W-1:0]         reduced_value_o,
  output logic                              last_of_frame_o
);

  logic [mpr_pkg::MAG_W-1:0]     left_q;
  logic [mpr_pkg::PAIR_W-1:0]    pair_q;
  logic                          out_valid_q;
  logic [mpr_pkg::SUM_W-1:0]     out_value_q;
  logic                          out_last_q;

  logic [mpr_pkg::MAG_W-1:0]     mag;
  logic [mpr_pkg::ROW_SUM_W-1:0] row_sum;
  logic [mpr_pkg::SUM_W-1:0]     col_base;
  logic [mpr_pkg::SUM_W-1:0]     total;
  logic                          produce;
  logic                          out_free;
  logic                          fire;

  // absolute value; the most negative code maps to its unsigned magnitude
  assign mag = s1_sample_i[mpr_pkg::SAMPLE_BITS-1] ? (mpr_pkg::MAG_W'(0) - s1_sample_i)
                                                   : s1_sample_i;

  assign row_sum  = mpr_pkg::ROW_SUM_W'(pair_q) + mpr_pkg::ROW_SUM_W'(mag);
  assign col_base = s1_ctrl_i.first_row ? '0 : rd_data_i;
  assign total    = rd_data_i + mpr_pkg::SUM_W'(row_sum);

  // handshake with the result register
  assign produce      = s1_ctrl_i.active && s1_ctrl_i.odd_col && s1_ctrl_i.odd_row;
  assign out_free     = !out_valid_q || result_ready_i;
  assign s1_advance_o = s1_valid_i && (!produce || out_free);
  assign fire         = s1_advance_o && s1_ctrl_i.active;

  // odd column: even rows accumulate, odd rows store the overlap row
  assign wr_en_o   = fire && s1_ctrl_i.odd_col;
  assign wr_slot_o = s1_ctrl_i.slot;
  assign wr_data_o = s1_ctrl_i.odd_row ? mpr_pkg::SUM_W'(row_sum)
                                       : col_base + mpr_pkg::SUM_W'(row_sum);

  // horizontal overlap state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      pair_q <= '0;
    end else if (fire) begin
      if (s1_ctrl_i.odd_col) begin
        left_q <= mag;
      end else begin
        pair_q <= (s1_ctrl_i.first_col ? mpr_pkg::PAIR_W'(0) : mpr_pkg::PAIR_W'(left_q)) +
                  mpr_pkg::PAIR_W'(mag);
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_advance_o && produce;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_advance_o && produce) begin
      out_value_q <= total;
      out_last_q  <= s1_ctrl_i.last;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign reduced_value_o = out_value_q;
  assign last_of_frame_o = out_last_q;

endmodule

/* sv/mask_pyramid_reduce.sv */
// mask_pyramid_reduce: 3x3 box sum with 2x decimation over a raster mask stream.
// Pixel (2i+1, 2j+1) yields a result via the input register, then the result register.
// Throughput: one sample per cycle, set by that register pair, while the result register is free;
// the line buffer is read and written once per two samples, a read and a write may share an edge.
// Reset: counters and flags clear, both size registers return to 1024; the line buffer
// is not cleared, row 0 of every frame overwrites it. Depends on mpr_pkg and submodules.
module mask_pyramid_reduce (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [0:0]                             cfg_index_i,
  input  logic [mpr_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                   sample_valid_i,
  output logic                                   sample_ready_o,
  input  logic signed [mpr_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                   result_valid_o,
  input  logic                                   result_ready_i,
  output logic [mpr_pkg::SUM_W-1:0]              reduced_value_o,
  output logic                                   last_of_frame_o
);

  logic                            s1_valid;
  logic                            s1_advance;
  logic [mpr_pkg::SAMPLE_BITS-1:0] s1_sample;
  mpr_pkg::stage_ctrl_t            s1_ctrl;
  logic                            rd_en;
  logic [mpr_pkg::SLOT_W-1:0]      rd_slot;
  logic [mpr_pkg::SUM_W-1:0]       rd_data;
  logic                            wr_en;
  logic [mpr_pkg::SLOT_W-1:0]      wr_slot;
  logic [mpr_pkg::SUM_W-1:0]       wr_data;

  // position tracking and input register
  mpr_input_stage u_input (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .s1_advance_i   (s1_advance),
    .s1_valid_o     (s1_valid),
    .s1_sample_o    (s1_sample),
    .s1_ctrl_o      (s1_ctrl),
    .rd_en_o        (rd_en),
    .rd_slot_o      (rd_slot)
  );

  // half-column partial sums
  mpr_line_buf u_line_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_slot_i (wr_slot),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_slot_i (rd_slot),
    .rd_data_o (rd_data)
  );

  // accumulation and result register
  mpr_accum_stage u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s1_valid_i      (s1_valid),
    .s1_sample_i     (s1_sample),
    .s1_ctrl_i       (s1_ctrl),
    .s1_advance_o    (s1_advance),
    .rd_data_i       (rd_data),
    .wr_en_o         (wr_en),
    .wr_slot_o       (wr_slot),
    .wr_data_o       (wr_data),
    .result_valid_o  (result_valid_o),
    .result_ready_i  (result_ready_i),
    .reduced_value_o (reduced_value_o),
    .last_of_frame_o (last_of_frame_o)
  );

  // input side only stalls behind an occupied input register
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_ready_o |-> s1_valid)
    else $error("input stalled with empty input register");

  // a result-producing request leaving stage one always lands in the result register
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_advance && s1_ctrl.active && s1_ctrl.odd_col && s1_ctrl.odd_row) |=> result_valid_o)
    else $error("result lost between stage one and the result register");

  // line buffer is only read on even columns and only written on odd columns
  a_buf_port_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (s1_ctrl.odd_col && s1_valid))
    else $error("line buffer written outside an odd column");

endmodule
